@@ hw/rtl/twt_pkg.sv @@
// ----------------------------------------------------------------------------
// twt_pkg
// Types and constants shared by the heartbeat watchdog table.
// ----------------------------------------------------------------------------
package twt_pkg;

	localparam int MAX_TASKS = 16;
	localparam int ADDR_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int SLOT_W    = 4;
	localparam int CMP_W     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	localparam logic [2:0] OP_REGISTER    = 3'd0;
	localparam logic [2:0] OP_HEARTBEAT   = 3'd1;
	localparam logic [2:0] OP_CHECK       = 3'd2;
	localparam logic [2:0] OP_SET_STATE   = 3'd3;
	localparam logic [2:0] OP_SET_MONITOR = 3'd4;

	localparam logic [2:0] PH_STARTING  = 3'd0;
	localparam logic [2:0] PH_RUNNING   = 3'd1;
	localparam logic [2:0] PH_WAITCLOCK = 3'd2;
	localparam logic [2:0] PH_WARNING   = 3'd3;
	localparam logic [2:0] PH_TIMEOUT   = 3'd4;
	localparam logic [2:0] PH_RECOVERED = 3'd5;
	localparam logic [2:0] PH_STOPPED   = 3'd6;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       now_ms;
		logic [31:0]       timeout_ms;
		logic              monitor_on;
		logic [2:0]        new_state;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic [SLOT_W-1:0] slot_out;
		logic              timed_out;
		logic [2:0]        state_out;
		logic [31:0]       beats;
	} rsp_t;

	typedef struct packed {
		logic [31:0] limit;
		logic [31:0] last_seen;
		logic [31:0] beats;
		logic [2:0]  phase;
		logic        watch;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_entry;
		logic              used_inc;
		rsp_t              rsp;
	} upd_t;

endpackage

@@ hw/rtl/twt_req_if.sv @@
// ----------------------------------------------------------------------------
// twt_req_if
// Request channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface twt_req_if;
	import twt_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/twt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// twt_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface twt_rsp_if;
	import twt_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/twt_update.sv @@
// ----------------------------------------------------------------------------
// twt_update
// Read-modify-write logic: decodes a command against the entry read from
// the table and produces the write-back, the count update and the result.
// ----------------------------------------------------------------------------
module twt_update (
	input  twt_pkg::req_t             req,
	input  twt_pkg::entry_t           rd_entry,
	input  logic [twt_pkg::CNT_W-1:0] used,
	output twt_pkg::upd_t             upd
);
	import twt_pkg::*;

	logic        in_use;
	logic        full;
	logic [31:0] elapsed;
	entry_t      nxt;

	assign in_use  = CMP_W'(req.slot) < CMP_W'(used);
	assign full    = (used == CNT_W'(MAX_TASKS));
	assign elapsed = req.now_ms - rd_entry.last_seen;

	always_comb begin
		nxt = rd_entry;
		upd = '0;
		upd.wr_addr = ADDR_W'(req.slot);
		upd.rsp.slot_out = req.slot;
		unique case (req.opcode) inside
			OP_REGISTER: begin
				if (!full) begin
					nxt.limit     = req.timeout_ms;
					nxt.last_seen = req.now_ms;
					nxt.beats     = '0;
					nxt.phase     = PH_STARTING;
					nxt.watch     = req.monitor_on;
					upd.wr_en     = 1'b1;
					upd.wr_addr   = ADDR_W'(used);
					upd.used_inc  = 1'b1;
					upd.rsp.accepted = 1'b1;
					upd.rsp.slot_out = SLOT_W'(used);
				end
			end
			OP_HEARTBEAT, OP_CHECK, OP_SET_STATE, OP_SET_MONITOR: begin
				if (in_use) begin
					upd.wr_en        = 1'b1;
					upd.rsp.accepted = 1'b1;
					unique case (req.opcode)
						OP_HEARTBEAT: begin
							nxt.last_seen = req.now_ms;
							nxt.beats     = rd_entry.beats + 32'd1;
							if (rd_entry.phase == PH_TIMEOUT)
								nxt.phase = PH_RECOVERED;
							else if (rd_entry.phase == PH_STARTING ||
								rd_entry.phase == PH_RECOVERED ||
								rd_entry.phase == PH_WARNING)
								nxt.phase = PH_RUNNING;
						end
						OP_CHECK: begin
							upd.rsp.timed_out = rd_entry.watch &&
								(rd_entry.limit != 32'd0) &&
								(elapsed > rd_entry.limit);
						end
						OP_SET_STATE: begin
							if (req.new_state <= PH_STOPPED)
								nxt.phase = req.new_state;
						end
						default: begin
							nxt.watch     = req.monitor_on;
							nxt.last_seen = req.now_ms;
						end
					endcase
					upd.rsp.state_out = nxt.phase;
					upd.rsp.beats     = nxt.beats;
				end
			end
			default: ;
		endcase
		upd.wr_entry = nxt;
	end
endmodule

@@ hw/rtl/task_heartbeat_watchdog_table_top.sv @@
// ----------------------------------------------------------------------------
// task_heartbeat_watchdog_table_top
// Heartbeat watchdog table for up to MAX_TASKS channels.
//
// Channels: req (command beats) and rsp (one result beat per command),
// both valid/ready. Commands register a channel, stamp a heartbeat, check
// for a timeout, force a phase or change the monitor enable.
// A taken command is held in stage one (rd_s1, req_s1) with its table
// read; the result is then registered in rsp_q and offered on rsp.
// The single-port table read on accept is followed by the write-back when
// the command finishes; a new command is taken only after the previous
// one has written back.
// The output register lets the next command enter while a result waits;
// if rsp stalls, the pending command holds its read data until the output
// register frees up, and req.ready stays low meanwhile.
// Reset clears the allocation count and all valid flags; table contents
// are not cleared and are written when a slot is registered.
// ----------------------------------------------------------------------------
module task_heartbeat_watchdog_table_top (
	input logic        clk,
	input logic        arst_n,
	twt_req_if.sink    req,
	twt_rsp_if.source  rsp
);
	import twt_pkg::*;

	entry_t            mem [MAX_TASKS];
	entry_t            rd_s1;
	req_t              req_s1;
	logic              v_s1;
	logic [CNT_W-1:0]  used_q;
	rsp_t              rsp_q;
	logic              rsp_v_q;
	logic              req_fire;
	logic              done;
	upd_t              upd;

	assign req.ready = !v_s1;
	assign req_fire  = req.valid && req.ready;
	assign done      = v_s1 && (!rsp_v_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (done && upd.wr_en)
			mem[upd.wr_addr] <= upd.wr_entry;
		if (req_fire) begin
			rd_s1  <= mem[ADDR_W'(req.data.slot)];
			req_s1 <= req.data;
		end
	end

	twt_update u_update (
		.req      (req_s1),
		.rd_entry (rd_s1),
		.used     (used_q),
		.upd      (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			used_q  <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			if (req_fire)
				v_s1 <= 1'b1;
			else if (done)
				v_s1 <= 1'b0;
			if (done && upd.used_inc)
				used_q <= used_q + CNT_W'(1);
			if (done)
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			rsp_q <= upd.rsp;
	end

	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_TASKS))
		else $error("allocation count beyond table size");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + CNT_W'(1))
		else $error("allocation count moved by more than one");

	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> v_s1 && !req.ready)
		else $error("command not held in stage one after accept");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rsp_v_q && !v_s1)
		else $error("finished command produced no result beat");
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the heartbeat watchdog table. A queue of commands, directed
// first and then random, feeds a clocked driver on req; a clocked monitor on
// rsp checks every result beat against a table model updated when each
// command is taken. Both channels idle at random, with one burst without gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import twt_pkg::*;

	localparam int N_RANDOM    = 1530;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BURST_LO    = 600;
	localparam int BURST_HI    = 900;
	localparam int IDLE_PCT    = 38;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	req_t req_data  = '0;
	logic rsp_ready = 1'b0;

	twt_req_if req_if ();
	twt_rsp_if rsp_if ();

	assign req_if.valid = req_valid;
	assign req_if.data  = req_data;
	assign rsp_if.ready = rsp_ready;

	task_heartbeat_watchdog_table_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	req_t   cmd_q[$];
	rsp_t   rsp_exp_q[$];
	entry_t chan_tbl[MAX_TASKS];
	logic [4:0] chan_cnt = '0;

	int taken_cnt  = 0;
	int rsp_cnt    = 0;
	int err_cnt    = 0;
	int tmo_cnt    = 0;
	int refuse_cnt = 0;
	int cycles     = 0;

	wire burst = (taken_cnt >= BURST_LO) && (taken_cnt < BURST_HI);

	function automatic rsp_t watchdog_predict(req_t c);
		rsp_t r;
		logic [31:0] elapsed;
		r = '0;
		r.slot_out = c.slot;
		if (c.opcode == OP_REGISTER) begin
			if (chan_cnt < MAX_TASKS) begin
				chan_tbl[chan_cnt[3:0]].limit     = c.timeout_ms;
				chan_tbl[chan_cnt[3:0]].last_seen = c.now_ms;
				chan_tbl[chan_cnt[3:0]].beats     = '0;
				chan_tbl[chan_cnt[3:0]].phase     = PH_STARTING;
				chan_tbl[chan_cnt[3:0]].watch     = c.monitor_on;
				r.accepted = 1'b1;
				r.slot_out = chan_cnt[3:0];
				chan_cnt   = chan_cnt + 5'd1;
			end
		end else if (c.opcode <= OP_SET_MONITOR && c.slot < chan_cnt) begin
			r.accepted = 1'b1;
			case (c.opcode)
				OP_HEARTBEAT: begin
					chan_tbl[c.slot].last_seen = c.now_ms;
					chan_tbl[c.slot].beats     = chan_tbl[c.slot].beats + 32'd1;
					if (chan_tbl[c.slot].phase == PH_TIMEOUT)
						chan_tbl[c.slot].phase = PH_RECOVERED;
					else if (chan_tbl[c.slot].phase == PH_STARTING ||
						chan_tbl[c.slot].phase == PH_RECOVERED ||
						chan_tbl[c.slot].phase == PH_WARNING)
						chan_tbl[c.slot].phase = PH_RUNNING;
				end
				OP_CHECK: begin
					elapsed = c.now_ms - chan_tbl[c.slot].last_seen;
					if (chan_tbl[c.slot].watch && chan_tbl[c.slot].limit != 32'd0)
						r.timed_out = (elapsed > chan_tbl[c.slot].limit);
				end
				OP_SET_STATE: begin
					if (c.new_state <= PH_STOPPED)
						chan_tbl[c.slot].phase = c.new_state;
				end
				default: begin
					chan_tbl[c.slot].watch     = c.monitor_on;
					chan_tbl[c.slot].last_seen = c.now_ms;
				end
			endcase
			r.state_out = chan_tbl[c.slot].phase;
			r.beats     = chan_tbl[c.slot].beats;
		end
		return r;
	endfunction

	function automatic req_t mk_cmd(logic [2:0] op, logic [3:0] sl, logic [31:0] now,
		logic [31:0] lim, logic mon, logic [2:0] ns);
		req_t c;
		c.opcode     = op;
		c.slot       = sl;
		c.now_ms     = now;
		c.timeout_ms = lim;
		c.monitor_on = mon;
		c.new_state  = ns;
		return c;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// driver: hold the beat until taken, then load the next one or idle
	always @(posedge clk or negedge arst_n) begin : drv
		logic idle;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else begin
			idle = !burst && ($urandom_range(0, 99) < IDLE_PCT);
			if (req_valid && req_if.ready) begin
				rsp_exp_q.push_back(watchdog_predict(req_data));
				taken_cnt++;
			end
			if (!req_valid || req_if.ready) begin
				if (cmd_q.size() > 0 && !idle) begin
					req_valid <= 1'b1;
					req_data  <= cmd_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : mon
		rsp_t e;
		rsp_t a;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_if.valid === 1'b1 && rsp_ready) begin
				a = rsp_if.data;
				rsp_cnt++;
				if (rsp_exp_q.size() == 0) begin
					$error("unexpected result beat: slot_out 0x%0h", a.slot_out);
					err_cnt++;
				end else begin
					e = rsp_exp_q.pop_front();
					check_field("accepted", 32'(e.accepted), 32'(a.accepted));
					check_field("slot_out", 32'(e.slot_out), 32'(a.slot_out));
					check_field("timed_out", 32'(e.timed_out), 32'(a.timed_out));
					check_field("state_out", 32'(e.state_out), 32'(a.state_out));
					check_field("beats", e.beats, a.beats);
					if (e.timed_out)
						tmo_cnt++;
					if (!e.accepted)
						refuse_cnt++;
				end
			end
			rsp_ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("task_heartbeat_watchdog_table_top verification failed");
			$finish;
		end
	end

	initial begin : stim
		logic [31:0] t_ms;
		logic [31:0] now;
		logic [31:0] lim;
		logic [3:0]  sl;
		logic [2:0]  op;
		int          gen_used;
		int          n;
		int          pick;
		int          n_total;

		// empty table, unused opcodes
		cmd_q.push_back(mk_cmd(OP_HEARTBEAT, 4'd0, 32'd0, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7));
		cmd_q.push_back(mk_cmd(3'd5, 4'd3, 32'd10, 32'd10, 1'b1, 3'd1));
		// slot 0: no limit, slot 1: max limit across wrap, 2 and 3: limit 100
		cmd_q.push_back(mk_cmd(OP_REGISTER, 4'd9, 32'd0, 32'd0, 1'b1, 3'd0));
		cmd_q.push_back(mk_cmd(OP_REGISTER, 4'd15, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 3'd7));
		cmd_q.push_back(mk_cmd(OP_REGISTER, 4'd0, 32'd1000, 32'd100, 1'b1, 3'd0));
		cmd_q.push_back(mk_cmd(OP_REGISTER, 4'd0, 32'd1000, 32'd100, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd1, 32'd5, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd2, 32'd1100, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd2, 32'd1101, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd3, 32'd5000, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_SET_STATE, 4'd2, 32'd0, 32'd0, 1'b0, PH_TIMEOUT));
		cmd_q.push_back(mk_cmd(OP_HEARTBEAT, 4'd2, 32'd1200, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_HEARTBEAT, 4'd2, 32'd1300, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_SET_STATE, 4'd2, 32'd0, 32'd0, 1'b0, 3'd7));
		cmd_q.push_back(mk_cmd(OP_SET_STATE, 4'd1, 32'd0, 32'd0, 1'b0, PH_WARNING));
		cmd_q.push_back(mk_cmd(OP_HEARTBEAT, 4'd1, 32'd20, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_SET_STATE, 4'd3, 32'd0, 32'd0, 1'b0, PH_STOPPED));
		cmd_q.push_back(mk_cmd(OP_HEARTBEAT, 4'd3, 32'd5500, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_SET_MONITOR, 4'd3, 32'd6000, 32'd0, 1'b1, 3'd0));
		cmd_q.push_back(mk_cmd(OP_CHECK, 4'd3, 32'd6101, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(OP_SET_MONITOR, 4'd4, 32'd6200, 32'd0, 1'b1, 3'd0));
		cmd_q.push_back(mk_cmd(3'd7, 4'd15, 32'd0, 32'd0, 1'b0, 3'd0));
		cmd_q.push_back(mk_cmd(3'd6, 4'd8, 32'd0, 32'd0, 1'b1, 3'd6));
		gen_used = 4;

		// time base starts near the top so the stamps wrap during the run
		t_ms = 32'hFFFF_F000;
		for (n = 0; n < N_RANDOM; n++) begin
			t_ms = t_ms + $urandom_range(0, 300);
			now  = ($urandom_range(0, 99) < 5) ? $urandom() : t_ms;
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0:       lim = 32'd0;
				1:       lim = 32'hFFFF_FFFF;
				2:       lim = $urandom();
				default: lim = $urandom_range(1, 400);
			endcase
			if (gen_used > 0 && $urandom_range(0, 99) < 90)
				sl = 4'($urandom_range(0, gen_used - 1));
			else
				sl = 4'($urandom_range(0, 15));
			if (pick < ((gen_used < MAX_TASKS) ? 10 : 2))
				op = OP_REGISTER;
			else if (pick < 45)
				op = OP_HEARTBEAT;
			else if (pick < 75)
				op = OP_CHECK;
			else if (pick < 86)
				op = OP_SET_STATE;
			else if (pick < 97)
				op = OP_SET_MONITOR;
			else
				op = 3'($urandom_range(5, 7));
			if (op == OP_REGISTER && gen_used < MAX_TASKS)
				gen_used++;
			cmd_q.push_back(mk_cmd(op, sl, now, lim, ($urandom_range(0, 99) < 80),
				3'($urandom_range(0, 7))));
		end
		n_total = cmd_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (rsp_cnt < n_total)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (rsp_exp_q.size() != 0) begin
			$error("%0d expected result beats never arrived", rsp_exp_q.size());
			err_cnt++;
		end

		$display("covered %0d commands, %0d results: %0d timeouts, %0d refused",
			taken_cnt, rsp_cnt, tmo_cnt, refuse_cnt);
		$display("table filled to %0d channels, %0d mismatches", chan_cnt, err_cnt);
		if (err_cnt == 0)
			$display("task_heartbeat_watchdog_table_top verification clean");
		else
			$display("task_heartbeat_watchdog_table_top verification failed");
		$finish;
	end

endmodule
